[hdl/sed_pkg.sv]
// Shared types and constants for the string escape decoder.
// Depends on nothing; imported by string_escape_decoder_unit.
package sed_pkg;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'd0,
		PH_ESCAPE = 3'd1,
		PH_HEX    = 3'd2,
		PH_OCTAL  = 3'd3
	} phase_t;

	// One decoded result word as it sits in the output queue.
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
		logic       fin;
	} result_t;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_V         = 8'h76;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_A         = 8'h61;

	localparam logic [7:0] CTL_NL  = 8'd10;
	localparam logic [7:0] CTL_TAB = 8'd9;
	localparam logic [7:0] CTL_VT  = 8'd11;
	localparam logic [7:0] CTL_FF  = 8'd12;
	localparam logic [7:0] CTL_BEL = 8'd7;

	localparam logic [1:0] HEX_DIGITS_MAX   = 2'd2;
	localparam logic [1:0] OCTAL_DIGITS_MAX = 2'd3;

endpackage

[hdl/string_escape_decoder_unit.sv]
// String literal escape decoder: input register, decode logic, two-word result queue.
// An accepted word is held in the input register, decoded, and written to the result queue that drives out_*.
// Throughput: one input word per cycle while the result queue has room; an input that yields
// two result words needs both queue entries free, so it waits behind a word still queued.
// Reset (arst_n low): escape state returns to normal, input stage and result queue empty.
// Depends on sed_pkg.
module string_escape_decoder_unit
	import sed_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       run_last,
	output logic       text_end
);

	// ---------------------------------------------------------------
	// Input register stage
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// Escape state
	phase_t     phase_q;
	logic [7:0] pend_q;
	logic [1:0] digits_q;

	// Result queue: entry 0 is the head
	result_t    head_q, tail_q;
	logic [1:0] cnt_q;

	// Decode outputs
	logic [1:0] n_res;
	logic [7:0] r0, r1;
	logic       r0_present;
	phase_t     phase_d;
	logic [7:0] pend_d;
	logic [1:0] digits_d;

	logic       pop, adv;
	logic [1:0] avail, free_slots;
	result_t    head_d, tail_d;
	logic [1:0] cnt_d;

	// ---------------------------------------------------------------
	// Character classes
	// ---------------------------------------------------------------
	function automatic logic is_octal(input logic [7:0] c);
		return c[7:3] == 5'b00110;
	endfunction

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		// bit 4 flags a valid hex digit, bits 3:0 hold its value
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic [8:0] control_for(input logic [7:0] c);
		// bit 8 flags a known control escape
		logic [8:0] r;
		r = 9'd0;
		case (c)
			CH_N:         r = {1'b1, CTL_NL};
			CH_T:         r = {1'b1, CTL_TAB};
			CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
			CH_QUOTE:     r = {1'b1, CH_QUOTE};
			CH_V:         r = {1'b1, CTL_VT};
			CH_F:         r = {1'b1, CTL_FF};
			CH_A:         r = {1'b1, CTL_BEL};
			default:      r = 9'd0;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Decode: one word in, up to two result bytes out, next escape state
	// ---------------------------------------------------------------
	always_comb begin
		logic [4:0] hd;
		logic [8:0] ctl;
		logic [7:0] nv;
		logic [1:0] nd;
		logic       plain;      // run the plain-byte path on byte_s1
		logic       plain_slot; // result slot the plain byte lands in

		hd         = hex_digit(byte_s1);
		ctl        = control_for(byte_s1);
		nv         = 8'd0;
		nd         = 2'd0;
		plain      = 1'b0;
		plain_slot = 1'b0;
		n_res      = 2'd0;
		r0         = 8'd0;
		r1         = 8'd0;
		r0_present = 1'b1;
		phase_d    = PH_NORMAL;
		pend_d     = 8'd0;
		digits_d   = 2'd0;

		case (phase_q)
			PH_ESCAPE: begin
				if (ctl[8]) begin
					r0    = ctl[7:0];
					n_res = 2'd1;
				end else if (byte_s1 == CH_X) begin
					if (fin_s1) begin
						r0    = CH_X;
						n_res = 2'd1;
					end else begin
						phase_d = PH_HEX;
					end
				end else if (is_octal(byte_s1)) begin
					if (fin_s1) begin
						r0    = {5'd0, byte_s1[2:0]};
						n_res = 2'd1;
					end else begin
						phase_d  = PH_OCTAL;
						pend_d   = {5'd0, byte_s1[2:0]};
						digits_d = 2'd1;
					end
				end else if (byte_s1 != CH_NEWLINE) begin
					r0    = byte_s1;
					n_res = 2'd1;
				end
			end
			PH_HEX: begin
				if (hd[4]) begin
					nv = {pend_q[3:0], hd[3:0]};
					nd = digits_q + 2'd1;
					if (nd >= HEX_DIGITS_MAX || fin_s1) begin
						r0    = nv;
						n_res = 2'd1;
					end else begin
						phase_d  = PH_HEX;
						pend_d   = nv;
						digits_d = nd;
					end
				end else begin
					// flush the open escape, then treat the byte as plain
					r0         = (digits_q != 2'd0) ? pend_q : CH_X;
					n_res      = 2'd1;
					plain      = 1'b1;
					plain_slot = 1'b1;
				end
			end
			PH_OCTAL: begin
				if (is_octal(byte_s1)) begin
					nv = {pend_q[4:0], byte_s1[2:0]};
					nd = digits_q + 2'd1;
					if (nd >= OCTAL_DIGITS_MAX || fin_s1) begin
						r0    = nv;
						n_res = 2'd1;
					end else begin
						phase_d  = PH_OCTAL;
						pend_d   = nv;
						digits_d = nd;
					end
				end else begin
					r0         = pend_q;
					n_res      = 2'd1;
					plain      = 1'b1;
					plain_slot = 1'b1;
				end
			end
			default: begin
				plain = 1'b1;
			end
		endcase

		if (plain) begin
			if (byte_s1 == CH_BACKSLASH && !fin_s1) begin
				phase_d = PH_ESCAPE;
			end else if (plain_slot) begin
				r1    = byte_s1;
				n_res = 2'd2;
			end else begin
				r0    = byte_s1;
				n_res = 2'd1;
			end
		end

		// end of text: drop all escape state, always give at least one result
		if (fin_s1) begin
			phase_d  = PH_NORMAL;
			pend_d   = 8'd0;
			digits_d = 2'd0;
			if (n_res == 2'd0) begin
				r0         = 8'd0;
				r0_present = 1'b0;
				n_res      = 2'd1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Handshake and queue bookkeeping
	// ---------------------------------------------------------------
	assign pop        = out_valid && out_ready;
	assign avail      = cnt_q - {1'b0, pop};
	assign free_slots = 2'd2 - avail;
	assign adv        = valid_s1 && (n_res <= free_slots);
	// take a new word whenever the input stage empties this cycle
	assign in_ready   = !valid_s1 || adv;

	always_comb begin
		result_t e0, e1;
		e0 = '{data: r0, present: r0_present, last: (n_res == 2'd1), fin: fin_s1};
		e1 = '{data: r1, present: 1'b1, last: 1'b1, fin: fin_s1};

		head_d = pop ? tail_q : head_q;
		tail_d = tail_q;
		cnt_d  = avail;
		if (adv && n_res != 2'd0) begin
			if (n_res == 2'd2) begin
				head_d = e0;
				tail_d = e1;
			end else if (avail == 2'd0) begin
				head_d = e0;
			end else begin
				tail_d = e0;
			end
			cnt_d = avail + n_res;
		end
	end

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_NORMAL;
			pend_q   <= 8'd0;
			digits_q <= 2'd0;
			cnt_q    <= 2'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				phase_q  <= phase_d;
				pend_q   <= pend_d;
				digits_q <= digits_d;
			end
			cnt_q <= cnt_d;
		end
	end

	// payload: hold unless loaded
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			fin_s1  <= final_byte;
		end
		head_q <= head_d;
		tail_q <= tail_d;
	end

	assign out_valid    = cnt_q != 2'd0;
	assign out_byte     = head_q.data;
	assign byte_present = head_q.present;
	assign run_last     = head_q.last;
	assign text_end     = head_q.fin;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_pair_whole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> cnt_q == 2'd2)
		else $error("first word of a pair shown without its partner");

	a_empty_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_present |-> run_last && text_end)
		else $error("empty result word outside a final step");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && fin_s1 |=> phase_q == PH_NORMAL && digits_q == 2'd0 && pend_q == 8'd0)
		else $error("escape state not cleared after final word");

endmodule

[tb/tb.sv]
// Self-checking testbench for string_escape_decoder_unit: a directed table, then random
// literal bodies, checked word by word against hand-typed results or an escape decoder model held here.
// Depends on sed_pkg and the unit; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
	import sed_pkg::*;

	// Digit bounds for hex and octal escapes
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_7  = 8'h37;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;

	localparam int RANDOM_WORDS = 1330;
	localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
	localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 8;     // room for a stray word to show up

	// One input word, with an optional hand-typed result for the directed table
	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		logic [7:0] exp_data;
		logic       exp_present;
	} stim_t;

	typedef enum int {
		TOK_PLAIN, TOK_CTRL, TOK_HEX, TOK_OCT, TOK_BSNL, TOK_ESC_ANY, TOK_HEX_LONG,
		TOK_OCT_LONG
	} token_t;

	// Directed table: plain extremes, control escapes, hex, bare hex, octal wrap,
	// flush plus byte, empty final step and trailing backslash.
	localparam stim_t DIRECTED [23] = '{
		'{8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
		'{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1},
		'{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_N, 1'b0, 1'b1, CTL_NL, 1'b1},
		'{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_QUOTE, 1'b0, 1'b1, CH_QUOTE, 1'b1},
		'{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_X, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h34, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h31, 1'b0, 1'b1, 8'h41, 1'b1},
		'{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_X, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h67, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_7, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_7, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_7, 1'b0, 1'b1, 8'hFF, 1'b1},
		'{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h31, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_9, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_NEWLINE, 1'b1, 1'b1, 8'h00, 1'b0},
		'{CH_BACKSLASH, 1'b1, 1'b1, CH_BACKSLASH, 1'b1}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_present;
	logic       run_last;
	logic       text_end;

	// Travels with the offered word so the monitor sees typed expectations
	logic    cur_typed = 1'b0;
	result_t cur_exp = '0;

	// Decoder model state
	phase_t     esc_phase = PH_NORMAL;
	logic [7:0] esc_value = '0;
	logic [1:0] esc_digits = '0;
	logic [7:0] step_bytes [2];
	int         step_count;

	result_t decoded_q [$];
	stim_t   random_q [$];

	int words_in = 0;
	int words_out = 0;
	int errors = 0;
	int texts = 0;
	int flush_pairs = 0;
	int empty_finals = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit held = 1'b0;

	string_escape_decoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_present(byte_present),
		.run_last(run_last),
		.text_end(text_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic emit(input logic [7:0] b);
		if (step_count < 2) begin
			step_bytes[step_count] = b;
			step_count++;
		end
	endtask

	task automatic close_escape();
		esc_phase = PH_NORMAL;
		esc_value = '0;
		esc_digits = '0;
	endtask

	// A backslash opens an escape unless it is the last byte of the body
	task automatic plain_byte(input logic [7:0] c, input logic fin);
		if (c == CH_BACKSLASH && !fin)
			esc_phase = PH_ESCAPE;
		else
			emit(c);
	endtask

	// Advance the decoder model by one input word; leaves its bytes in step_bytes
	task automatic decode_word(input logic [7:0] c, input logic fin);
		int         d;
		logic       is_ctl;
		logic [7:0] ctl;
		step_count = 0;
		case (esc_phase)
			PH_ESCAPE: begin
				is_ctl = 1'b1;
				ctl = '0;
				case (c)
					CH_N:         ctl = CTL_NL;
					CH_T:         ctl = CTL_TAB;
					CH_BACKSLASH: ctl = CH_BACKSLASH;
					CH_QUOTE:     ctl = CH_QUOTE;
					CH_V:         ctl = CTL_VT;
					CH_F:         ctl = CTL_FF;
					CH_A:         ctl = CTL_BEL;
					default:      is_ctl = 1'b0;
				endcase
				close_escape();
				if (is_ctl) begin
					emit(ctl);
				end else if (c == CH_X) begin
					if (fin)
						emit(CH_X);
					else
						esc_phase = PH_HEX;
				end else if (c >= CH_0 && c <= CH_7) begin
					if (fin) begin
						emit(c - CH_0);
					end else begin
						esc_phase = PH_OCTAL;
						esc_value = c - CH_0;
						esc_digits = 2'd1;
					end
				end else if (c != CH_NEWLINE) begin
					emit(c);
				end
			end
			PH_HEX: begin
				if (c >= CH_0 && c <= CH_9)
					d = int'(c - CH_0);
				else if (c >= CH_A && c <= CH_F)
					d = int'(c - CH_A) + 10;
				else if (c >= CH_UA && c <= CH_UF)
					d = int'(c - CH_UA) + 10;
				else
					d = -1;
				if (d >= 0) begin
					esc_value = {esc_value[3:0], d[3:0]};
					esc_digits = esc_digits + 2'd1;
					if (esc_digits >= HEX_DIGITS_MAX || fin) begin
						emit(esc_value);
						close_escape();
					end
				end else begin
					// bare \x gives 'x'; the stopping byte is then taken as plain
					emit(esc_digits != 2'd0 ? esc_value : CH_X);
					close_escape();
					plain_byte(c, fin);
				end
			end
			PH_OCTAL: begin
				if (c >= CH_0 && c <= CH_7) begin
					esc_value = {esc_value[4:0], c[2:0]};
					esc_digits = esc_digits + 2'd1;
					if (esc_digits >= OCTAL_DIGITS_MAX || fin) begin
						emit(esc_value);
						close_escape();
					end
				end else begin
					emit(esc_value);
					close_escape();
					plain_byte(c, fin);
				end
			end
			default: begin
				close_escape();
				plain_byte(c, fin);
			end
		endcase
		if (fin)
			close_escape();
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
		end
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return CH_0 + 8'(v);
		return ($urandom_range(0, 1) ? CH_A : CH_UA) + 8'(v - 10);
	endfunction

	// Build one literal body out of random tokens; mark its last byte final
	task automatic gen_text();
		logic [7:0] body [$];
		logic [7:0] ctl_chars [7];
		token_t     kind;
		int         tokens;
		int         n;
		bit         noise;
		stim_t      w;
		ctl_chars = '{CH_N, CH_T, CH_BACKSLASH, CH_QUOTE, CH_V, CH_F, CH_A};
		tokens = $urandom_range(1, 10);
		noise = ($urandom_range(0, 7) == 0);
		for (int t = 0; t < tokens; t++) begin
			kind = token_t'($urandom_range(0, 7));
			if (noise || $urandom_range(0, 3) == 0)
				kind = TOK_PLAIN;
			if (kind != TOK_PLAIN)
				body = {body, CH_BACKSLASH};
			case (kind)
				TOK_PLAIN:   body = {body, 8'($urandom_range(0, 255))};
				TOK_CTRL:    body = {body, ctl_chars[3'($urandom_range(0, 6))]};
				TOK_BSNL:    body = {body, CH_NEWLINE};
				TOK_ESC_ANY: body = {body, 8'($urandom_range(0, 255))};
				TOK_HEX, TOK_HEX_LONG: begin
					body = {body, CH_X};
					n = (kind == TOK_HEX) ? $urandom_range(0, 2) : 3;
					repeat (n) body = {body, hex_char()};
				end
				default: begin
					// octal: one to three digits, or four to spill one into plain
					n = (kind == TOK_OCT) ? $urandom_range(1, 3) : 4;
					repeat (n) body = {body, CH_0 + 8'($urandom_range(0, 7))};
				end
			endcase
		end
		foreach (body[i]) begin
			w = '0;
			w.b = body[i];
			w.fin = (i == body.size() - 1);
			random_q = {random_q, w};
		end
	endtask

	// Offer one word in bursts with random gaps; return at the falling edge after accept
	task automatic send_word(input stim_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte <= w.b;
		final_byte <= w.fin;
		cur_typed <= w.typed;
		cur_exp <= '{data: w.exp_data, present: w.exp_present, last: 1'b1, fin: w.fin};
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Check result words, then predict for the accepted input word, then watch for hangs
	always @(posedge clk) begin
		result_t want;
		result_t nxt;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				words_out++;
				if (decoded_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: expected none, got byte %h present %b last %b end %b",
						$time, out_byte, byte_present, run_last, text_end);
				end else begin
					want = decoded_q.pop_front();
					check_field("out_byte", want.data, out_byte);
					check_field("byte_present", {7'd0, want.present}, {7'd0, byte_present});
					check_field("run_last", {7'd0, want.last}, {7'd0, run_last});
					check_field("text_end", {7'd0, want.fin}, {7'd0, text_end});
				end
			end
			if (in_valid && in_ready) begin
				words_in++;
				decode_word(in_byte, final_byte);
				if (final_byte)
					texts++;
				if (step_count == 2)
					flush_pairs++;
				if (cur_typed) begin
					decoded_q = {decoded_q, cur_exp};
				end else if (step_count == 0 && final_byte) begin
					// a final word always answers, even with nothing decoded
					empty_finals++;
					nxt = '{data: 8'h00, present: 1'b0, last: 1'b1, fin: 1'b1};
					decoded_q = {decoded_q, nxt};
				end else begin
					for (int k = 0; k < step_count; k++) begin
						nxt = '{data: step_bytes[k], present: 1'b1,
							last: (k == step_count - 1), fin: final_byte};
						decoded_q = {decoded_q, nxt};
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d words still expected",
					$time, STALL_LIMIT, decoded_q.size());
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// Receiver: switch between always ready, a fixed stall pattern and coin flips;
	// once, hold off long enough that the unit fills and blocks its input.
	initial begin
		int rx_cyc;
		int rx_mode;
		rx_cyc = 0;
		rx_mode = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && words_in >= 400) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rx_cyc++;
			if (rx_cyc % 64 == 0)
				rx_mode = $urandom_range(0, 2);
			case (rx_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= (rx_cyc % 5 != 0) && (rx_cyc % 7 != 3);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (DIRECTED[i])
			send_word(DIRECTED[i]);
		while (random_q.size() < RANDOM_WORDS)
			gen_text();
		foreach (random_q[i])
			send_word(random_q[i]);
		in_valid <= 1'b0;
		// Drain, then give a stray word time to show up
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb: %0d words in, %0d words out over %0d bodies", words_in, words_out, texts);
		$display("tb: %0d flush-plus-byte steps, %0d empty final steps, %0d errors",
			flush_pairs, empty_finals, errors);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

[string_escape_decoder_unit.f]
hdl/sed_pkg.sv
hdl/string_escape_decoder_unit.sv
tb/tb.sv
